FILE: sv/bmc_pkg.sv
// Shared types and constants for the binary morphology row filter.
package bmc_pkg;

	localparam int DATA_W          = 64;
	localparam int DEF_MAX_COLUMNS = 64;
	localparam int WIDTH_W         = 7;
	localparam int THR_W           = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 7;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [THR_W-1:0]   NBR_CROSS     = THR_W'(4);
	localparam logic [THR_W-1:0]   NBR_FULL      = THR_W'(8);
	localparam logic [WIDTH_W-1:0] RESET_COLUMNS = WIDTH_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ERODE_MODE       = 2'd0,
		REG_EIGHT_NEIGHBOURS = 2'd1,
		REG_COUNT_THRESHOLD  = 2'd2,
		REG_COLUMNS_IN_USE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROWS_NONE = 2'd0,
		ROWS_ONE  = 2'd1,
		ROWS_TWO  = 2'd2
	} rows_t;

	// Settings every lane needs for its decision.
	typedef struct packed {
		logic             erode_mode;
		logic             eight_neighbours;
		logic [THR_W-1:0] count_threshold;
	} lane_cfg_t;

	typedef struct packed {
		logic              is_last;
		logic [DATA_W-1:0] result_pixels;
	} out_word_t;

endpackage

FILE: sv/bmc_lane.sv
// One column lane: neighbour count and flip decision for one interior pixel.
module bmc_lane
	import bmc_pkg::*;
(
	input  logic      [2:0] up,
	input  logic      [2:0] mid,
	input  logic      [2:0] dn,
	input  lane_cfg_t       cfg,
	input  logic            active,
	output logic            flip
);

	logic [THR_W-1:0] fg_cross;
	logic [THR_W-1:0] fg_diag;
	logic [THR_W-1:0] fg;
	logic [THR_W-1:0] total;
	logic [THR_W-1:0] bg;

	always_comb begin
		fg_cross = THR_W'(up[1]) + THR_W'(dn[1]) + THR_W'(mid[0]) + THR_W'(mid[2]);
		fg_diag  = THR_W'(up[0]) + THR_W'(up[2]) + THR_W'(dn[0]) + THR_W'(dn[2]);
		fg       = cfg.eight_neighbours ? fg_cross + fg_diag : fg_cross;
		total    = cfg.eight_neighbours ? NBR_FULL : NBR_CROSS;
		bg       = total - fg;
		if (cfg.erode_mode) begin
			flip = active & mid[1] & (bg > cfg.count_threshold);
		end else begin
			flip = active & ~mid[1] & (fg > cfg.count_threshold);
		end
	end

endmodule

FILE: sv/bmc_out_queue.sv
// Output word queue: takes up to two words a cycle, hands out one while ready.
module bmc_out_queue
	import bmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic              push1,
	input  out_word_t         word0,
	input  out_word_t         word1,
	output logic              space_ok,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,
	output logic              m_axis_tlast
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	out_word_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [CNT_W-1:0] n_push;

	assign pop           = m_axis_tvalid & m_axis_tready;
	assign n_push        = CNT_W'(push0) + CNT_W'(push1);
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = mem_q[rd_ptr_q].result_pixels;
	assign m_axis_tlast  = mem_q[rd_ptr_q].is_last;
	// Room for the two words a flushing last row may bring.
	assign space_ok      = (count_q <= CNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= word0;
		end
		if (push1) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= word1;
		end
	end

endmodule

FILE: sv/binary_morph_2d_count_core.sv
// Top level of the streaming 3x3 binary dilation / erosion row filter.
//
// Input channel s_axis_*: one image row per word, bit c of tdata is the pixel
// at column c, tlast marks the final row of the image. Output channel
// m_axis_*: one processed row per word, tlast marks the final output row.
// The cfg_* port writes the mode, neighbourhood, threshold and width
// registers; write it only while no row is in flight.
// Each row is held until the row below it arrives, so output row n leaves
// with input row n+1 and enters the output queue when that input is taken.
// A last row flushes two words: the pending row and the last row itself.
// A single-row image gives one word.
// While the queue has room, one row is taken per cycle: all column lanes
// decide in parallel in that cycle, and a four-word output queue absorbs
// the extra flush word. When the receiver stalls, the queue fills and
// s_axis_tready drops once fewer than two slots are free.
// Reset empties the queue and the row history and sets dilation, the
// 4-neighbourhood, threshold 0 and a width of 64 columns.
module binary_morph_2d_count_core
	import bmc_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,   // [63:0] row_pixels
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_W-1:0]     m_axis_tdata,   // [63:0] result_pixels
	output logic                  m_axis_tlast
);

	lane_cfg_t          lane_cfg_q;
	logic [WIDTH_W-1:0] columns_q;
	rows_t              rows_q;
	rows_t              rows_next;
	logic [DATA_W-1:0]  prev_q;
	logic [DATA_W-1:0]  center_q;

	logic [WIDTH_W-1:0] eff_w;
	logic [DATA_W-1:0]  mask;
	logic [DATA_W-1:0]  row_m;
	logic [DATA_W-1:0]  prev_m;
	logic [DATA_W-1:0]  center_m;
	logic [DATA_W-1:0]  flips;
	logic               accept;
	logic               space_ok;
	logic               push0;
	logic               push1;
	out_word_t          word0;
	out_word_t          word1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_cfg_q <= '0;
			columns_q  <= RESET_COLUMNS;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ERODE_MODE:       lane_cfg_q.erode_mode       <= cfg_data[0];
				REG_EIGHT_NEIGHBOURS: lane_cfg_q.eight_neighbours <= cfg_data[0];
				REG_COUNT_THRESHOLD:  lane_cfg_q.count_threshold  <= cfg_data[THR_W-1:0];
				REG_COLUMNS_IN_USE:   columns_q                   <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_w = (columns_q > WIDTH_W'(MAX_COLUMNS)) ? WIDTH_W'(MAX_COLUMNS) : columns_q;

	always_comb begin
		for (int c = 0; c < DATA_W; c++) begin
			mask[c] = (WIDTH_W'(c) < eff_w);
		end
	end

	assign row_m    = s_axis_tdata & mask;
	assign prev_m   = prev_q & mask;
	assign center_m = center_q & mask;
	assign accept   = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = space_ok;

	// One lane per interior column; border columns never flip.
	assign flips[0]                      = 1'b0;
	assign flips[DATA_W-1:MAX_COLUMNS-1] = '0;

	for (genvar c = 1; c < MAX_COLUMNS - 1; c++) begin : g_lane
		bmc_lane u_lane (
			.up     (prev_m[c+1:c-1]),
			.mid    (center_m[c+1:c-1]),
			.dn     (row_m[c+1:c-1]),
			.cfg    (lane_cfg_q),
			.active (WIDTH_W'(c + 1) < eff_w),
			.flip   (flips[c])
		);
	end

	// Row history sequencer: next state.
	always_comb begin
		rows_next = rows_q;
		if (accept) begin
			if (s_axis_tlast) begin
				rows_next = ROWS_NONE;
			end else if (rows_q == ROWS_NONE) begin
				rows_next = ROWS_ONE;
			end else begin
				rows_next = ROWS_TWO;
			end
		end
	end

	// Row history sequencer: merge lane results into output words.
	always_comb begin
		push0               = 1'b0;
		push1               = 1'b0;
		word0.is_last       = 1'b0;
		word0.result_pixels = row_m;
		word1.is_last       = 1'b1;
		word1.result_pixels = row_m;
		unique case (rows_q)
			ROWS_NONE: begin
				push0         = accept & s_axis_tlast;
				word0.is_last = 1'b1;
			end
			ROWS_ONE: begin
				push0               = accept;
				push1               = accept & s_axis_tlast;
				word0.result_pixels = center_m;
			end
			ROWS_TWO: begin
				push0               = accept;
				push1               = accept & s_axis_tlast;
				word0.result_pixels = center_m ^ flips;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_NONE;
		end else begin
			rows_q <= rows_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q   <= center_q;
			center_q <= row_m;
		end
	end

	bmc_out_queue u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push0         (push0),
		.push1         (push1),
		.word0         (word0),
		.word1         (word1),
		.space_ok      (space_ok),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: sv/bmc_checker.sv
// Port-level checks for the row filter, bound to the top level.
module bmc_checker
	import bmc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [DATA_W-1:0]     m_axis_tdata,
	input logic                  m_axis_tlast
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// Back-pressure only comes from words waiting in the queue.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready while output is empty");

	// A word can only appear after an input row was taken.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |=> !m_axis_tvalid || $past(s_axis_tvalid && s_axis_tready))
		else $error("output word without an input row");

	// A last row taken on an empty queue shows up on the next cycle.
	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && s_axis_tvalid && s_axis_tready && s_axis_tlast |=>
			m_axis_tvalid)
		else $error("last row produced no output word");

endmodule

bind binary_morph_2d_count_core bmc_checker u_bmc_checker (.*);

FILE: sim/morph_row_checker.sv
`timescale 1ns / 1ps
// Scoreboard that mirrors the morphology row filter and checks every output word.
module morph_row_checker
	import bmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,   // [63:0] row_pixels
	input  logic                  s_axis_tlast,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [DATA_W-1:0]     m_axis_tdata,   // [63:0] result_pixels
	input  logic                  m_axis_tlast,
	output int                    mismatches,
	output int                    outstanding,
	output int                    words_checked
);

	localparam int MAX_PRINT = 40;

	// Shadow copy of the register file.
	logic             mode_erode;
	logic             mode_eight;
	logic [THR_W-1:0] thr_value;
	logic [WIDTH_W-1:0] cols_value;

	// Row history of the image in flight.
	logic [DATA_W-1:0] row_above;
	logic [DATA_W-1:0] row_pending;
	rows_t             rows_held;

	out_word_t expected_rows[$];

	function automatic int active_columns();
		return (int'(cols_value) > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(cols_value);
	endfunction

	function automatic logic [DATA_W-1:0] column_mask(input int w);
		if (w >= DATA_W)
			return '1;
		return (DATA_W'(1) << w) - DATA_W'(1);
	endfunction

	// One row of the threshold filter; only interior columns can change.
	function automatic logic [DATA_W-1:0] morph_row(input logic [DATA_W-1:0] up,
			input logic [DATA_W-1:0] mid, input logic [DATA_W-1:0] dn, input int w);
		logic [DATA_W-1:0] res;
		int fg;
		int total;
		res = mid;
		for (int c = 1; c + 1 < w; c++) begin
			fg = int'(up[c]) + int'(dn[c]) + int'(mid[c-1]) + int'(mid[c+1]);
			total = int'(NBR_CROSS);
			if (mode_eight) begin
				fg += int'(up[c-1]) + int'(up[c+1]) + int'(dn[c-1]) + int'(dn[c+1]);
				total = int'(NBR_FULL);
			end
			if (!mode_erode) begin
				if (!mid[c] && fg > int'(thr_value))
					res[c] = 1'b1;
			end else if (mid[c] && total - fg > int'(thr_value)) begin
				res[c] = 1'b0;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINT)
			$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		int w;
		logic [DATA_W-1:0] wmask;
		logic [DATA_W-1:0] row;
		out_word_t want;
		if (!arst_n) begin
			mode_erode    = 1'b0;
			mode_eight    = 1'b0;
			thr_value     = '0;
			cols_value    = RESET_COLUMNS;
			row_above     = '0;
			row_pending   = '0;
			rows_held     = ROWS_NONE;
			expected_rows.delete();
			mismatches    = 0;
			outstanding   = 0;
			words_checked = 0;
		end else begin
			// Output side first: a word leaving now belongs to rows taken earlier.
			if (m_axis_tvalid && m_axis_tready) begin
				words_checked++;
				if (expected_rows.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h last %0b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = expected_rows.pop_front();
					if (m_axis_tdata !== want.result_pixels)
						report_mismatch($sformatf("word %0d result_pixels expected %h got %h",
							words_checked, want.result_pixels, m_axis_tdata));
					if (m_axis_tlast !== want.is_last)
						report_mismatch($sformatf("word %0d is_last expected %0b got %0b",
							words_checked, want.is_last, m_axis_tlast));
				end
			end

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ERODE_MODE:       mode_erode = cfg_data[0];
					REG_EIGHT_NEIGHBOURS: mode_eight = cfg_data[0];
					REG_COUNT_THRESHOLD:  thr_value  = cfg_data[THR_W-1:0];
					REG_COLUMNS_IN_USE:   cols_value = cfg_data[WIDTH_W-1:0];
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				w     = active_columns();
				wmask = column_mask(w);
				row   = s_axis_tdata & wmask;
				if (rows_held == ROWS_NONE) begin
					if (s_axis_tlast) begin
						want.is_last       = 1'b1;
						want.result_pixels = row;
						expected_rows.push_back(want);
					end else begin
						row_pending = row;
						rows_held   = ROWS_ONE;
					end
				end else begin
					// The first row of an image is a border row and passes through.
					want.is_last       = 1'b0;
					want.result_pixels = (rows_held == ROWS_ONE) ? (row_pending & wmask) :
						(morph_row(row_above & wmask, row_pending & wmask, row, w) & wmask);
					expected_rows.push_back(want);
					if (s_axis_tlast) begin
						want.is_last       = 1'b1;
						want.result_pixels = row;
						expected_rows.push_back(want);
					end else begin
						row_above   = row_pending;
						row_pending = row;
						rows_held   = ROWS_TWO;
					end
				end
				if (s_axis_tlast) begin
					row_above   = '0;
					row_pending = '0;
					rows_held   = ROWS_NONE;
				end
			end
			outstanding = expected_rows.size();
		end
	end

endmodule

FILE: sim/tb_binary_morph_2d_count_core.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, row stimulus and verdict for the morphology row filter.
module tb_binary_morph_2d_count_core;
	import bmc_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int MAX_GAP        = 17;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TARGET_ROWS    = 1600;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;   // [63:0] row_pixels
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [DATA_W-1:0]     m_axis_tdata;   // [63:0] result_pixels
	logic                  m_axis_tlast;

	int mismatches;
	int outstanding;
	int words_checked;
	int rows_sent     = 0;
	int images_sent   = 0;
	int settings_used = 0;
	int idle_cycles   = 0;
	int hold_asked    = 0;
	int hold_done     = 0;
	bit tx_idle       = 1'b1;
	bit rx_idle       = 1'b1;

	binary_morph_2d_count_core i_dut (.*);

	morph_row_checker i_checker (.*);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the handshake.
	task automatic send_row(input logic [DATA_W-1:0] pixels, input logic last);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pixels;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		rows_sent++;
		if (last)
			images_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering rows and wait until every expected word has left the block.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic erode, input logic eight, input int thr,
			input int cols);
		drain();
		write_reg(REG_ERODE_MODE, CFG_DATA_W'(erode));
		write_reg(REG_EIGHT_NEIGHBOURS, CFG_DATA_W'(eight));
		write_reg(REG_COUNT_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(REG_COLUMNS_IN_USE, CFG_DATA_W'(cols));
		settings_used++;
	endtask

	// Rows of varying density, so that thresholds below eight see flips and non-flips.
	function automatic logic [DATA_W-1:0] draw_row();
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0:       return a;
			1:       return a & b;
			2:       return a & b & c;
			3:       return a | b;
			4:       return a | b | c;
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	initial begin : receiver
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_asked != hold_done) begin
				hold_done++;
				gap = LONG_HOLD;
			end else begin
				gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int n_rows;
		int n_images;
		int thr;
		int cols;
		cfg_we        = 1'b0;
		cfg_index     = REG_ERODE_MODE;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: dilation, 4-neighborhood, threshold 0, 64 columns.
		send_row('1, 1'b1);
		send_row('0, 1'b0);
		send_row('1, 1'b1);
		send_row('0, 1'b0);
		send_row({32{2'b01}}, 1'b0);
		send_row({32{2'b10}}, 1'b0);
		send_row('1, 1'b1);

		// Narrowest useful image: one interior pixel, upper input bits are noise.
		configure(1'b1, 1'b1, 0, 3);
		send_row('1, 1'b0);
		send_row({$urandom, $urandom} | 64'h7, 1'b0);
		send_row(64'h5, 1'b1);

		// A threshold of eight can never be exceeded.
		configure(1'b1, 1'b1, 8, 64);
		send_row('1, 1'b0);
		send_row({8{8'hF7}}, 1'b0);
		send_row('0, 1'b1);

		configure(1'b0, 1'b0, 15, 64);
		send_row('0, 1'b0);
		send_row({16{4'h2}}, 1'b0);
		send_row('0, 1'b1);

		// Zero width gives empty rows, width two has no interior.
		configure(1'b0, 1'b1, 0, 0);
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);

		configure(1'b0, 1'b1, 0, 2);
		send_row('1, 1'b0);
		send_row('0, 1'b0);
		send_row('1, 1'b1);

		// A width register above the maximum acts as the full width.
		configure(1'b0, 1'b0, 0, 127);
		send_row({32{2'b10}}, 1'b0);
		send_row('0, 1'b0);
		send_row({32{2'b01}}, 1'b1);

		for (int phase = 0; rows_sent < TARGET_ROWS; phase++) begin
			case ($urandom_range(0, 7))
				0:       thr = $urandom_range(9, 15);
				1:       thr = $urandom_range(5, 8);
				default: thr = $urandom_range(0, 4);
			endcase
			case ($urandom_range(0, 9))
				0:       cols = 3;
				1:       cols = 64;
				2:       cols = $urandom_range(0, 2);
				3:       cols = $urandom_range(65, 127);
				default: cols = $urandom_range(4, 63);
			endcase
			configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), thr, cols);
			tx_idle  = ($urandom_range(0, 3) != 0);
			rx_idle  = ($urandom_range(0, 3) != 0);
			n_images = $urandom_range(1, 4);
			// Once, the receiver holds off while rows keep coming, so the block
			// fills its output queue and stalls the input.
			if (phase == 1) begin
				tx_idle  = 1'b0;
				n_images = 4;
				hold_asked++;
			end
			repeat (n_images) begin
				case ($urandom_range(0, 9))
					0:       n_rows = 1;
					1:       n_rows = 2;
					default: n_rows = $urandom_range(3, 24);
				endcase
				for (int r = 0; r < n_rows; r++)
					send_row(draw_row(), r == n_rows - 1);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d rows in %0d images under %0d register settings; %0d words checked.",
			rows_sent, images_sent, settings_used, words_checked);
		$display("Dilation and erosion, both neighborhoods, narrow to oversized widths, with stalls.");
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
